// ----- design/psat_pkg.sv -----
// ----------------------------------------------------------------------------
// psat_pkg
// Shared types, widths and codes of the profile sample accumulation table.
// ----------------------------------------------------------------------------
`default_nettype none

package psat_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned TICK_W = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned USED_W = 7;
  localparam int unsigned STAT_W = 3;

  localparam int unsigned TABLE_SLOTS_DEF  = 64;
  localparam int unsigned ADDRESS_BITS_DEF = 48;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_ALLOCATED = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ      = 3'd3,
    ST_ZERO      = 3'd4
  } psat_status_e;

  // Read address source for the entry RAM
  typedef enum logic [1:0] {
    RA_ITEM,  // slot named by the item (read slot, or slot 0 for a scan)
    RA_NEXT,  // scan index plus one
    RA_CUR    // scan index, keeps the read data steady
  } psat_raddr_e;

  typedef enum logic [2:0] {
    RES_UPDATE,
    RES_ALLOC,
    RES_FULL,
    RES_ZERO,
    RES_READ_HIT,
    RES_READ_EMPTY
  } psat_res_e;

  typedef struct packed {
    logic        load;
    psat_raddr_e ra_sel;
    logic        step;
    logic        res_load;
    psat_res_e   res_kind;
  } psat_cmd_t;

  typedef struct packed {
    logic op;
    logic addr_zero;
    logic used_zero;
    logic in_range;
    logic match;
    logic last;
    logic full;
    logic out_busy;
  } psat_stat_t;

endpackage

`default_nettype wire

// ----- design/psat_ram.sv -----
// ----------------------------------------------------------------------------
// psat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/psat_ctrl.sv -----
// ----------------------------------------------------------------------------
// psat_ctrl
// Sequencer: accepts one item, drives the slot scan and result loading.
// ----------------------------------------------------------------------------
`default_nettype none

module psat_ctrl
  import psat_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire psat_stat_t stat_i,
  output psat_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RDWAIT,
    S_ALLOC
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o.load       = 1'b0;
    cmd_o.ra_sel     = RA_CUR;
    cmd_o.step       = 1'b0;
    cmd_o.res_load   = 1'b0;
    cmd_o.res_kind   = RES_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.op) begin
          if (stat_i.in_range) begin
            cmd_o.ra_sel = RA_ITEM;
            state_d      = S_RDWAIT;
          end else if (!stat_i.out_busy) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_READ_EMPTY;
            state_d        = S_IDLE;
          end
        end else if (stat_i.addr_zero) begin
          if (!stat_i.out_busy) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_ZERO;
            state_d        = S_IDLE;
          end
        end else if (stat_i.used_zero) begin
          state_d = S_ALLOC;
        end else begin
          cmd_o.ra_sel = RA_ITEM;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        // read data holds the entry at the scan index
        if (stat_i.match) begin
          if (!stat_i.out_busy) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = RES_UPDATE;
            state_d        = S_IDLE;
          end
        end else if (stat_i.last) begin
          state_d = S_ALLOC;
        end else begin
          cmd_o.ra_sel = RA_NEXT;
          cmd_o.step   = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd_o.ra_sel = RA_ITEM;
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = RES_READ_HIT;
          state_d        = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = stat_i.full ? RES_FULL : RES_ALLOC;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/psat_dp.sv -----
// ----------------------------------------------------------------------------
// psat_dp
// Datapath: item registers, entry RAM, scan index, fill count, base tick
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psat_dp
  import psat_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS  = TABLE_SLOTS_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psat_cmd_t         cmd_i,
  output psat_stat_t             stat_o,
  input  wire logic              in_operation_i,
  input  wire logic [ADDR_W-1:0] in_code_address_i,
  input  wire logic [TICK_W-1:0] in_start_tick_i,
  input  wire logic [TICK_W-1:0] in_end_tick_i,
  input  wire logic [SLOT_W-1:0] in_read_slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [STAT_W-1:0] out_status_o,
  output logic      [SLOT_W-1:0] out_slot_index_o,
  output logic      [ADDR_W-1:0] out_slot_address_o,
  output logic      [CNT_W-1:0]  out_slot_samples_o,
  output logic      [TICK_W-1:0] out_slot_cycle_total_o,
  output logic      [TICK_W-1:0] out_slot_first_start_o,
  output logic      [USED_W-1:0] out_used_slots_o,
  output logic      [TICK_W-1:0] out_base_tick_o
);

  localparam int unsigned SA_W   = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int unsigned IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNTU_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned CMP_W  = (CNTU_W > SLOT_W) ? CNTU_W : SLOT_W;
  // entry layout, low to high: address, samples, total, first start
  localparam int unsigned ENT_W  = SA_W + CNT_W + 2 * TICK_W;
  localparam int unsigned CNT_LO = SA_W;
  localparam int unsigned TOT_LO = SA_W + CNT_W;
  localparam int unsigned FST_LO = SA_W + CNT_W + TICK_W;

  logic              op_q;
  logic [SA_W-1:0]   addr_q;
  logic [TICK_W-1:0] start_q;
  logic [TICK_W-1:0] elapsed_q;
  logic [SLOT_W-1:0] rslot_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNTU_W-1:0] used_q, used_d;
  logic [TICK_W-1:0] base_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic [SA_W-1:0]   rd_addr;
  logic [CNT_W-1:0]  rd_cnt;
  logic [TICK_W-1:0] rd_tot;
  logic [TICK_W-1:0] rd_fst;

  logic [CNT_W-1:0]  new_cnt;
  logic [TICK_W-1:0] new_tot;

  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_idx;
  logic [SA_W-1:0]   res_addr;
  logic [CNT_W-1:0]  res_cnt;
  logic [TICK_W-1:0] res_tot;
  logic [TICK_W-1:0] res_fst;
  logic              out_valid_q;

  assign rd_addr = ram_rdata[SA_W-1:0];
  assign rd_cnt  = ram_rdata[CNT_LO +: CNT_W];
  assign rd_tot  = ram_rdata[TOT_LO +: TICK_W];
  assign rd_fst  = ram_rdata[FST_LO +: TICK_W];

  assign new_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1);
  assign new_tot = rd_tot + elapsed_q;

  // Slots are claimed lowest first and never freed, so slots below the
  // fill count are exactly the occupied ones.
  always_comb begin
    stat_o.op        = op_q;
    stat_o.addr_zero = (addr_q == '0);
    stat_o.used_zero = (used_q == '0);
    stat_o.in_range  = (CMP_W'(rslot_q) < CMP_W'(used_q));
    stat_o.match     = (rd_addr == addr_q);
    stat_o.last      = ((CNTU_W'(idx_q) + CNTU_W'(1)) == used_q);
    stat_o.full      = (used_q == CNTU_W'(TABLE_SLOTS));
    stat_o.out_busy  = out_valid_q & ~out_ready_i;
  end

  always_comb begin
    unique case (cmd_i.ra_sel)
      RA_ITEM: ram_raddr = op_q ? IDX_W'(rslot_q) : '0;
      RA_NEXT: ram_raddr = idx_q + IDX_W'(1);
      RA_CUR:  ram_raddr = idx_q;
      default: ram_raddr = idx_q;
    endcase
  end

  always_comb begin
    used_d     = used_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    res_status = ST_ZERO;
    res_idx    = '0;
    res_addr   = '0;
    res_cnt    = '0;
    res_tot    = '0;
    res_fst    = '0;
    unique case (cmd_i.res_kind)
      RES_UPDATE: begin
        ram_we     = cmd_i.res_load;
        res_status = ST_UPDATED;
        res_idx    = SLOT_W'(idx_q);
        res_addr   = rd_addr;
        res_cnt    = new_cnt;
        res_tot    = new_tot;
        res_fst    = rd_fst;
      end
      RES_ALLOC: begin
        ram_we     = cmd_i.res_load;
        ram_waddr  = IDX_W'(used_q);
        used_d     = used_q + CNTU_W'(1);
        res_status = ST_ALLOCATED;
        res_idx    = SLOT_W'(used_q);
        res_addr   = addr_q;
        res_cnt    = CNT_W'(1);
        res_tot    = elapsed_q;
        res_fst    = start_q;
      end
      RES_FULL: begin
        res_status = ST_FULL;
      end
      RES_ZERO: begin
        res_status = ST_ZERO;
      end
      RES_READ_HIT: begin
        res_status = ST_READ;
        res_idx    = rslot_q;
        res_addr   = rd_addr;
        res_cnt    = rd_cnt;
        res_tot    = rd_tot;
        res_fst    = rd_fst;
      end
      RES_READ_EMPTY: begin
        res_status = ST_READ;
        res_idx    = rslot_q;
      end
      default: begin
        res_status = ST_ZERO;
      end
    endcase
  end

  assign ram_wdata = {res_fst, res_tot, res_cnt, res_addr};

  psat_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= in_operation_i;
      addr_q    <= SA_W'(in_code_address_i);
      start_q   <= in_start_tick_i;
      elapsed_q <= in_end_tick_i - in_start_tick_i;
      rslot_q   <= in_read_slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      used_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      // base tick follows every record transaction until it is nonzero
      if (cmd_i.load && !in_operation_i && base_q == '0) begin
        base_q <= in_start_tick_i;
      end
      if (cmd_i.res_load) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_o           <= res_status;
      out_slot_index_o       <= res_idx;
      out_slot_address_o     <= ADDR_W'(res_addr);
      out_slot_samples_o     <= res_cnt;
      out_slot_cycle_total_o <= res_tot;
      out_slot_first_start_o <= res_fst;
      out_used_slots_o       <= USED_W'(used_d);
      out_base_tick_o        <= base_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/profile_sample_accumulation_table_top.sv -----
// ----------------------------------------------------------------------------
// profile_sample_accumulation_table_top
// Table of profiling entries keyed by code address, fed by sample and read
// transactions.
// ----------------------------------------------------------------------------
// One transaction is in work at a time and each gives exactly one result.
// A record transaction scans the occupied slots through the entry RAM, one
// slot per cycle. An update ends the scan at the matching slot, while an
// allocation or a drop on a full table first scans every occupied slot. A
// read of an occupied slot waits for the RAM read data; a read of an empty
// slot and an ignored zero address give their result straight from decode.
// A result that is not taken holds the sequencer for as long as it waits.
// The RAM scan sets the record time. Slots fill from 0 upward and are never
// freed, so the fill count marks which entries hold data and no clearing
// pass is needed after reset. A new transaction is taken while the previous
// result still waits in the output register.
`default_nettype none

module profile_sample_accumulation_table_top
  import psat_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS  = TABLE_SLOTS_DEF,
  parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // code_address, start_tick, end_tick, read_slot, 2 zero bits
  input  wire logic [183:0] s_axis_tdata,
  // operation
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // slot_index, slot_address, slot_samples, slot_cycle_total,
  // slot_first_start, used_slots, base_tick_out, 3 zero bits
  output logic      [287:0] m_axis_tdata,
  // status
  output logic      [2:0]   m_axis_tuser
);

  psat_cmd_t  cmd;
  psat_stat_t stat;

  logic [SLOT_W-1:0] slot_index;
  logic [ADDR_W-1:0] slot_address;
  logic [CNT_W-1:0]  slot_samples;
  logic [TICK_W-1:0] slot_cycle_total;
  logic [TICK_W-1:0] slot_first_start;
  logic [USED_W-1:0] used_slots;
  logic [TICK_W-1:0] base_tick;

  psat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  psat_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .in_operation_i        (s_axis_tuser[0]),
    .in_code_address_i     (s_axis_tdata[47:0]),
    .in_start_tick_i       (s_axis_tdata[111:48]),
    .in_end_tick_i         (s_axis_tdata[175:112]),
    .in_read_slot_i        (s_axis_tdata[181:176]),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .out_status_o          (m_axis_tuser),
    .out_slot_index_o      (slot_index),
    .out_slot_address_o    (slot_address),
    .out_slot_samples_o    (slot_samples),
    .out_slot_cycle_total_o(slot_cycle_total),
    .out_slot_first_start_o(slot_first_start),
    .out_used_slots_o      (used_slots),
    .out_base_tick_o       (base_tick)
  );

  assign m_axis_tdata = {3'b000, base_tick, used_slots, slot_first_start,
                         slot_cycle_total, slot_samples, slot_address, slot_index};

endmodule

`default_nettype wire

// ----- sim/profile_sample_accumulation_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_sample_accumulation_table_top_tb
// Self-checking bench for the profiling sample table. A driver streams record
// and read transactions from a queue. A monitor predicts each accepted
// transaction with a local copy of the table, then checks every returned
// entry field by field. The random part fills the table past its capacity.
// ----------------------------------------------------------------------------
module profile_sample_accumulation_table_top_tb;
  import psat_pkg::*;

  localparam int unsigned SLOTS     = TABLE_SLOTS_DEF;
  localparam int unsigned POOL_SIZE = 72;  // more hot addresses than slots
  localparam int unsigned HALF_RUN  = 800;

  typedef struct packed {
    logic              op;  // 1: read slot
    logic [ADDR_W-1:0] addr;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] stop_tick;
    logic [SLOT_W-1:0] rslot;
  } sample_item_t;

  typedef struct packed {
    psat_status_e      status;
    logic [SLOT_W-1:0] idx;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  samples;
    logic [TICK_W-1:0] total;
    logic [TICK_W-1:0] first;
    logic [USED_W-1:0] used;
    logic [TICK_W-1:0] base;
  } slot_report_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // code_address, start_tick, end_tick, read_slot, 2 zero bits
  logic [183:0] s_axis_tdata;
  // operation
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // slot_index, slot_address, slot_samples, slot_cycle_total,
  // slot_first_start, used_slots, base_tick_out, 3 zero bits
  logic [287:0] m_axis_tdata;
  // status
  logic [2:0]   m_axis_tuser;

  // local copy of the profiling table
  logic [ADDR_W-1:0] slot_addr_m  [SLOTS];
  logic [CNT_W-1:0]  slot_count_m [SLOTS];
  logic [TICK_W-1:0] slot_total_m [SLOTS];
  logic [TICK_W-1:0] slot_first_m [SLOTS];
  logic [USED_W-1:0] fill_m;
  logic [TICK_W-1:0] base_tick_m;

  sample_item_t pending_q[$];
  slot_report_t expected_q[$];

  int error_count;
  int items_sent;
  int result_count;
  int status_seen[8];
  int hold_left;
  bit hold_done;

  profile_sample_accumulation_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one transaction to the local table and returns the entry it reports.
  function automatic slot_report_t account_sample(sample_item_t it);
    slot_report_t r;
    int hit;
    logic [TICK_W-1:0] elapsed;
    r   = '0;
    hit = -1;
    if (it.op) begin
      r.status = ST_READ;
      r.idx    = it.rslot;
      hit      = int'(it.rslot);
    end else begin
      if (base_tick_m == '0) base_tick_m = it.start_tick;
      if (it.addr == '0) begin
        r.status = ST_ZERO;
      end else begin
        elapsed = it.stop_tick - it.start_tick;
        for (int i = 0; i < SLOTS && hit < 0; i++)
          if (slot_addr_m[i] == it.addr) hit = i;
        if (hit >= 0) begin
          slot_total_m[hit] = slot_total_m[hit] + elapsed;
          if (slot_count_m[hit] != CNT_MAX) slot_count_m[hit]++;
          r.status = ST_UPDATED;
        end else begin
          for (int i = 0; i < SLOTS && hit < 0; i++)
            if (slot_addr_m[i] == '0) hit = i;
          if (hit >= 0) begin
            slot_addr_m[hit]  = it.addr;
            slot_count_m[hit] = CNT_W'(1);
            slot_total_m[hit] = elapsed;
            slot_first_m[hit] = it.start_tick;
            fill_m++;
            r.status = ST_ALLOCATED;
          end else begin
            r.status = ST_FULL;
          end
        end
        if (hit >= 0) r.idx = SLOT_W'(hit);
      end
    end
    // dropped and ignored samples report an all-zero entry
    if (hit >= 0 && slot_addr_m[hit] != '0) begin
      r.addr    = slot_addr_m[hit];
      r.samples = slot_count_m[hit];
      r.total   = slot_total_m[hit];
      r.first   = slot_first_m[hit];
    end
    r.used = fill_m;
    r.base = base_tick_m;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("ERROR result %0d %s: got 0x%0h expected 0x%0h",
             result_count, field, got, want);
  endtask

  // Driver: offers the next pending item, idling about one cycle in ten
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      items_sent    <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 &&
          ((items_sent >= 1000 && items_sent < 1300) || $urandom_range(99) >= 10)) begin
        sample_item_t it;
        it = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.rslot, it.stop_tick, it.start_tick, it.addr};
        s_axis_tuser  <= it.op;
        items_sent    <= items_sent + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the input backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && result_count >= 300) begin
      hold_left     <= 400;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (result_count >= 1000 && result_count < 1300) ||
                       ($urandom_range(99) >= 10);
    end
  end

  // Monitor: check results, then predict newly accepted transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        slot_report_t want;
        result_count++;
        status_seen[m_axis_tuser]++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tdata[5:0] != want.idx)
            report_mismatch("slot_index", m_axis_tdata[5:0], want.idx);
          if (m_axis_tdata[53:6] != want.addr)
            report_mismatch("slot_address", m_axis_tdata[53:6], want.addr);
          if (m_axis_tdata[85:54] != want.samples)
            report_mismatch("slot_samples", m_axis_tdata[85:54], want.samples);
          if (m_axis_tdata[149:86] != want.total)
            report_mismatch("slot_cycle_total", m_axis_tdata[149:86], want.total);
          if (m_axis_tdata[213:150] != want.first)
            report_mismatch("slot_first_start", m_axis_tdata[213:150], want.first);
          if (m_axis_tdata[220:214] != want.used)
            report_mismatch("used_slots", m_axis_tdata[220:214], want.used);
          if (m_axis_tdata[284:221] != want.base)
            report_mismatch("base_tick_out", m_axis_tdata[284:221], want.base);
          if (m_axis_tdata[287:285] != 3'b000)
            report_mismatch("pad bits", m_axis_tdata[287:285], '0);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(account_sample(sample_item_t'({s_axis_tuser,
            s_axis_tdata[47:0], s_axis_tdata[111:48], s_axis_tdata[175:112],
            s_axis_tdata[181:176]})));
    end
  end

  initial begin
    logic [ADDR_W-1:0] pool [POOL_SIZE];
    sample_item_t it;
    int roll;
    rst_ni = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_addr_m[i]  = '0;
      slot_count_m[i] = '0;
      slot_total_m[i] = '0;
      slot_first_m[i] = '0;
    end
    fill_m      = '0;
    base_tick_m = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool[k] = ADDR_W'(rand64());
      if (pool[k] == '0) pool[k] = ADDR_W'(k + 1);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty reads, zero address, wrapping elapsed times, base tick
    pending_q.push_back('{1'b1, '0, '0, '0, 6'd0});
    pending_q.push_back('{1'b1, '1, '1, '1, 6'd63});
    pending_q.push_back('{1'b0, '0, '0, 64'd7, 6'd0});   // ignored, start 0 keeps base unset
    pending_q.push_back('{1'b0, '1, '0, '1, 6'd0});      // allocate, largest elapsed
    pending_q.push_back('{1'b0, '1, '1, '0, 6'd63});     // update, total wraps to 0
    pending_q.push_back('{1'b0, '0, 64'd123, 64'd9, 6'd5});
    pending_q.push_back('{1'b0, 48'd1, 64'd100, 64'd40, 6'd0});  // end before start
    pending_q.push_back('{1'b0, 48'd1, '0, '0, 6'd0});
    pending_q.push_back('{1'b0, 48'h8000_0000_0000, 64'd1, 64'd2, 6'd0});
    for (int s = 0; s < 4; s++)
      pending_q.push_back('{1'b1, '0, '0, '0, SLOT_W'(s)});
    pending_q.push_back('{1'b1, 48'h5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'h5555_5555_5555_5555, 6'd62});
    @(negedge clk_i);
    // sender holds back until the directed part has fully drained
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(negedge clk_i);

    for (int phase = 0; phase < 2; phase++) begin
      for (int n = 0; n < HALF_RUN; n++) begin
        roll          = $urandom_range(99);
        it.op         = (roll < 15);
        it.rslot      = SLOT_W'($urandom_range(SLOTS - 1));
        it.start_tick = rand64();
        if ($urandom_range(99) < 70)
          it.stop_tick = it.start_tick + 64'($urandom_range(100000));
        else
          it.stop_tick = rand64();
        if (roll < 15 || (roll >= 20 && roll < 25))
          it.addr = ADDR_W'(rand64());
        else if (roll < 20)
          it.addr = '0;
        else
          it.addr = pool[$urandom_range(POOL_SIZE - 1)];
        pending_q.push_back(it);
      end
      @(negedge clk_i);
      while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
        @(negedge clk_i);
    end

    repeat (100) @(negedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results never returned", expected_q.size(), '0);
    $display("Run: %0d transactions, %0d results, table filled to %0d of %0d slots",
             items_sent, result_count, fill_m, SLOTS);
    $display("Outcomes: %0d updated, %0d allocated, %0d dropped full, %0d ignored, %0d reads",
             status_seen[ST_UPDATED], status_seen[ST_ALLOCATED], status_seen[ST_FULL],
             status_seen[ST_ZERO], status_seen[ST_READ]);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT after %0d results", result_count);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- profile_sample_accumulation_table_top.f -----
design/psat_pkg.sv
design/psat_ram.sv
design/psat_ctrl.sv
design/psat_dp.sv
design/profile_sample_accumulation_table_top.sv
sim/profile_sample_accumulation_table_top_tb.sv
